// File: hdl/stunp_pkg.sv
// Shared types, codes and constants for the STUN message parser.
package stunp_pkg;

  localparam int unsigned HDR_BYTES   = 20;
  localparam int unsigned ALIGN_BYTES = 4;
  localparam int unsigned TXID_FIRST  = 8;
  localparam int unsigned POS_W       = 17;
  localparam int unsigned QDEPTH      = 4;
  localparam int unsigned QPTR_W      = $clog2(QDEPTH);
  localparam int unsigned QCNT_W      = $clog2(QDEPTH + 1);
  localparam int unsigned CFG_IDX_W   = 4;

  localparam logic [POS_W-1:0] POS_MAX = '1;

  // Result kinds
  localparam logic [1:0] KIND_USERNAME = 2'd0;
  localparam logic [1:0] KIND_TXID     = 2'd1;
  localparam logic [1:0] KIND_SUMMARY  = 2'd2;

  // Username parts
  localparam logic [1:0] PART_LOCAL  = 2'd0;
  localparam logic [1:0] PART_COLON  = 2'd1;
  localparam logic [1:0] PART_REMOTE = 2'd2;

  // Summary status
  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_SHORT    = 2'd1;
  localparam logic [1:0] ST_MISMATCH = 2'd2;
  localparam logic [1:0] ST_OVERRUN  = 2'd3;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_USERNAME       = 4'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_USE_CANDIDATE  = 4'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_ICE_CONTROLLED = 4'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_ICE_CONTROLLING = 4'd3;

  localparam logic [15:0] RST_CODE_USERNAME        = 16'd6;
  localparam logic [15:0] RST_CODE_USE_CANDIDATE   = 16'd37;
  localparam logic [15:0] RST_CODE_ICE_CONTROLLED  = 16'd32809;
  localparam logic [15:0] RST_CODE_ICE_CONTROLLING = 16'd32810;

  // Seen flag bits
  localparam int unsigned FLAG_USE   = 0;
  localparam int unsigned FLAG_CTRLD = 1;
  localparam int unsigned FLAG_CTRLG = 2;
  localparam int unsigned FLAG_COLON = 3;

  typedef enum logic [7:0] {
    PH_HEADER  = 8'b0000_0001,
    PH_TYPE_HI = 8'b0000_0010,
    PH_TYPE_LO = 8'b0000_0100,
    PH_LEN_HI  = 8'b0000_1000,
    PH_LEN_LO  = 8'b0001_0000,
    PH_VALUE   = 8'b0010_0000,
    PH_PAD     = 8'b0100_0000,
    PH_IGNORE  = 8'b1000_0000
  } phase_t;

  typedef struct packed {
    logic [15:0] username;
    logic [15:0] use_candidate;
    logic [15:0] ice_controlled;
    logic [15:0] ice_controlling;
  } cfg_codes_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [7:0]  data_byte;
    logic [1:0]  username_part;
    logic        attribute_start;
    logic [15:0] message_type;
    logic [1:0]  status;
    logic        use_candidate;
    logic        ice_controlled;
    logic        ice_controlling;
    logic        colon_seen;
    logic        end_of_run;
  } result_t;

  // Up to two results per accepted byte: a data byte, then a summary
  typedef struct packed {
    logic    v0;
    result_t r0;
    logic    v1;
    result_t r1;
  } push_t;

endpackage

// File: hdl/stun_message_parser.sv
// Latency: the first result of a byte is offered on the cycle after the byte is
// accepted when the queue is empty; a summary behind a data byte follows once it is taken.
// Throughput: one byte per cycle while the queue has room; each byte yields up to two
// results, drained one per cycle while out_ready is high, through a four-entry result
// queue that holds the input off while fewer than two entries are free.
// Reset (rst_n low, synchronous) returns to the start of a message, empties
// the queue and restores the default attribute type codes.
module stun_message_parser
  import stunp_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [7:0]           in_octet,
  input  logic                 in_final_octet,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [1:0]           out_kind,
  output logic [7:0]           out_data_byte,
  output logic [1:0]           out_username_part,
  output logic                 out_attribute_start,
  output logic [15:0]          out_message_type,
  output logic [1:0]           out_status,
  output logic                 out_use_candidate,
  output logic                 out_ice_controlled,
  output logic                 out_ice_controlling,
  output logic                 out_colon_seen,
  output logic                 out_end_of_run,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [15:0]          cfg_data
);

  cfg_codes_t codes;
  push_t      push;
  result_t    head;
  logic       in_fire;

  assign in_fire = in_valid && in_ready;

  stunp_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .codes     (codes)
  );

  stunp_parser u_parser (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_fire        (in_fire),
    .in_octet       (in_octet),
    .in_final_octet (in_final_octet),
    .codes          (codes),
    .push           (push)
  );

  stunp_out_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .room      (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .head      (head)
  );

  assign out_kind            = head.kind;
  assign out_data_byte       = head.data_byte;
  assign out_username_part   = head.username_part;
  assign out_attribute_start = head.attribute_start;
  assign out_message_type    = head.message_type;
  assign out_status          = head.status;
  assign out_use_candidate   = head.use_candidate;
  assign out_ice_controlled  = head.ice_controlled;
  assign out_ice_controlling = head.ice_controlling;
  assign out_colon_seen      = head.colon_seen;
  assign out_end_of_run      = head.end_of_run;

endmodule

// File: hdl/stunp_cfg_regs.sv
// Attribute type code registers behind the configuration write channel.
module stunp_cfg_regs
  import stunp_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [15:0]          cfg_data,
  output cfg_codes_t           codes
);

  cfg_codes_t codes_r;

  assign cfg_ready = 1'b1;
  assign codes     = codes_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      codes_r.username        <= RST_CODE_USERNAME;
      codes_r.use_candidate   <= RST_CODE_USE_CANDIDATE;
      codes_r.ice_controlled  <= RST_CODE_ICE_CONTROLLED;
      codes_r.ice_controlling <= RST_CODE_ICE_CONTROLLING;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        CFG_USERNAME:        codes_r.username        <= cfg_data;
        CFG_USE_CANDIDATE:   codes_r.use_candidate   <= cfg_data;
        CFG_ICE_CONTROLLED:  codes_r.ice_controlled  <= cfg_data;
        CFG_ICE_CONTROLLING: codes_r.ice_controlling <= cfg_data;
        default: ;
      endcase
    end
  end

endmodule

// File: hdl/stunp_parser.sv
// Byte-serial header and attribute walker; produces result records per byte.
module stunp_parser
  import stunp_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_fire,
  input  logic [7:0] in_octet,
  input  logic       in_final_octet,
  input  cfg_codes_t codes,
  output push_t      push
);

  logic [POS_W-1:0] byte_pos_r,   byte_pos_nxt;
  phase_t           phase_r,      phase_nxt;
  logic [15:0]      msg_type_r,   msg_type_nxt;
  logic [15:0]      msg_len_r,    msg_len_nxt;
  logic [15:0]      attr_type_r,  attr_type_nxt;
  logic [15:0]      attr_len_r,   attr_len_nxt;
  logic [15:0]      attr_left_r,  attr_left_nxt;
  logic [1:0]       pad_left_r,   pad_left_nxt;
  logic [3:0]       flags_r,      flags_nxt;
  logic             overrun_r,    overrun_nxt;

  logic [POS_W-1:0] end_pos;
  logic [POS_W-1:0] bytes_to_end;
  logic [15:0]      len_full;
  logic [15:0]      left_dec;
  logic [1:0]       pad;
  logic [1:0]       part;
  logic [POS_W:0]   count;
  logic             is_user;

  assign end_pos      = POS_W'(HDR_BYTES) + {1'b0, msg_len_r};
  assign bytes_to_end = end_pos - byte_pos_r;
  assign len_full     = {attr_len_r[15:8], in_octet};
  assign left_dec     = attr_left_r - 16'd1;
  assign pad          = 2'b00 - attr_len_r[1:0];
  assign count        = {1'b0, byte_pos_r} + (POS_W+1)'(1);
  assign is_user      = (attr_type_r == codes.username);

  always_comb begin
    byte_pos_nxt  = byte_pos_r;
    phase_nxt     = phase_r;
    msg_type_nxt  = msg_type_r;
    msg_len_nxt   = msg_len_r;
    attr_type_nxt = attr_type_r;
    attr_len_nxt  = attr_len_r;
    attr_left_nxt = attr_left_r;
    pad_left_nxt  = pad_left_r;
    flags_nxt     = flags_r;
    overrun_nxt   = overrun_r;
    push          = '0;
    part          = PART_LOCAL;

    if (in_fire) begin
      if (phase_r == PH_HEADER) begin
        if (byte_pos_r < POS_W'(2)) begin
          msg_type_nxt = {msg_type_r[7:0], in_octet};
        end else if (byte_pos_r < POS_W'(4)) begin
          msg_len_nxt = {msg_len_r[7:0], in_octet};
        end else if (byte_pos_r >= POS_W'(TXID_FIRST)) begin
          push.v0           = 1'b1;
          push.r0.kind      = KIND_TXID;
          push.r0.data_byte = in_octet;
        end
        if (byte_pos_r >= POS_W'(HDR_BYTES - 1)) phase_nxt = PH_TYPE_HI;
      end else if (phase_r != PH_IGNORE && byte_pos_r >= end_pos) begin
        // past the declared end: never parse as attributes
        phase_nxt = PH_IGNORE;
      end else begin
        unique case (phase_r)
          PH_TYPE_HI: begin
            if (bytes_to_end < POS_W'(ALIGN_BYTES)) begin
              phase_nxt = PH_IGNORE;
            end else begin
              attr_type_nxt = {in_octet, 8'h00};
              phase_nxt     = PH_TYPE_LO;
            end
          end
          PH_TYPE_LO: begin
            attr_type_nxt = {attr_type_r[15:8], in_octet};
            phase_nxt     = PH_LEN_HI;
          end
          PH_LEN_HI: begin
            attr_len_nxt = {in_octet, 8'h00};
            phase_nxt    = PH_LEN_LO;
          end
          PH_LEN_LO: begin
            attr_len_nxt = len_full;
            if ({1'b0, len_full} > bytes_to_end - POS_W'(1)) begin
              overrun_nxt = 1'b1;
              phase_nxt   = PH_IGNORE;
            end else begin
              priority if (is_user) begin
                flags_nxt[FLAG_COLON] = 1'b0;
              end else if (attr_type_r == codes.use_candidate) begin
                flags_nxt[FLAG_USE] = 1'b1;
              end else if (attr_type_r == codes.ice_controlled) begin
                flags_nxt[FLAG_CTRLD] = 1'b1;
              end else if (attr_type_r == codes.ice_controlling) begin
                flags_nxt[FLAG_CTRLG] = 1'b1;
              end else begin
              end
              if (len_full == 16'd0) begin
                phase_nxt = PH_TYPE_HI;
              end else begin
                attr_left_nxt = len_full;
                phase_nxt     = PH_VALUE;
              end
            end
          end
          PH_VALUE: begin
            if (is_user) begin
              // tag around the first colon of this username value
              if (flags_r[FLAG_COLON]) begin
                part = PART_REMOTE;
              end else if (in_octet == 8'h3A) begin
                part                  = PART_COLON;
                flags_nxt[FLAG_COLON] = 1'b1;
              end else begin
                part = PART_LOCAL;
              end
              push.v0                 = 1'b1;
              push.r0.kind            = KIND_USERNAME;
              push.r0.data_byte       = in_octet;
              push.r0.username_part   = part;
              push.r0.attribute_start = (attr_left_r == attr_len_r);
            end
            attr_left_nxt = left_dec;
            if (left_dec == 16'd0) begin
              if (pad != 2'd0) begin
                pad_left_nxt = pad;
                phase_nxt    = PH_PAD;
              end else begin
                phase_nxt = PH_TYPE_HI;
              end
            end
          end
          PH_PAD: begin
            pad_left_nxt = pad_left_r - 2'd1;
            if (pad_left_r == 2'd1) phase_nxt = PH_TYPE_HI;
          end
          default: ;
        endcase
      end

      byte_pos_nxt = (byte_pos_r < POS_MAX) ? byte_pos_r + POS_W'(1) : POS_MAX;

      if (in_final_octet) begin
        push.v1            = 1'b1;
        push.r1.kind       = KIND_SUMMARY;
        push.r1.end_of_run = 1'b1;
        if (count < (POS_W+1)'(HDR_BYTES)) begin
          push.r1.status = ST_SHORT;
        end else if (count != {1'b0, end_pos}) begin
          push.r1.status       = ST_MISMATCH;
          push.r1.message_type = msg_type_nxt;
        end else begin
          push.r1.status          = overrun_nxt ? ST_OVERRUN : ST_OK;
          push.r1.message_type    = msg_type_nxt;
          push.r1.use_candidate   = flags_nxt[FLAG_USE];
          push.r1.ice_controlled  = flags_nxt[FLAG_CTRLD];
          push.r1.ice_controlling = flags_nxt[FLAG_CTRLG];
          push.r1.colon_seen      = flags_nxt[FLAG_COLON];
        end
        // return to the start of a message
        byte_pos_nxt  = '0;
        phase_nxt     = PH_HEADER;
        msg_type_nxt  = '0;
        msg_len_nxt   = '0;
        attr_type_nxt = '0;
        attr_len_nxt  = '0;
        attr_left_nxt = '0;
        pad_left_nxt  = '0;
        flags_nxt     = '0;
        overrun_nxt   = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      byte_pos_r  <= '0;
      phase_r     <= PH_HEADER;
      msg_type_r  <= '0;
      msg_len_r   <= '0;
      attr_type_r <= '0;
      attr_len_r  <= '0;
      attr_left_r <= '0;
      pad_left_r  <= '0;
      flags_r     <= '0;
      overrun_r   <= 1'b0;
    end else begin
      byte_pos_r  <= byte_pos_nxt;
      phase_r     <= phase_nxt;
      msg_type_r  <= msg_type_nxt;
      msg_len_r   <= msg_len_nxt;
      attr_type_r <= attr_type_nxt;
      attr_len_r  <= attr_len_nxt;
      attr_left_r <= attr_left_nxt;
      pad_left_r  <= pad_left_nxt;
      flags_r     <= flags_nxt;
      overrun_r   <= overrun_nxt;
    end
  end

  a_final_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && in_final_octet) |=> (byte_pos_r == '0 && phase_r == PH_HEADER))
    else $error("message state not cleared after last byte");

  a_pad_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == PH_PAD) |-> (pad_left_r != 2'd0))
    else $error("padding phase with no padding left");

  a_header_pos: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == PH_HEADER) |-> (byte_pos_r < POS_W'(HDR_BYTES)))
    else $error("header phase past the header");

endmodule

// File: hdl/stunp_out_queue.sv
// Small result queue: takes up to two records per cycle, delivers one while out_ready is high.
module stunp_out_queue
  import stunp_pkg::*;
(
  input  logic    clk,
  input  logic    rst_n,
  input  push_t   push,
  output logic    room,
  output logic    out_valid,
  input  logic    out_ready,
  output result_t head
);

  result_t           q_r [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QCNT_W-1:0] count_r,  count_nxt;
  logic [QPTR_W-1:0] wr_ptr_p1;
  logic [1:0]        n_wr;
  logic              rd;
  result_t           first_rec;

  function automatic logic [QPTR_W-1:0] ptr_inc(input logic [QPTR_W-1:0] p);
    ptr_inc = (p == QPTR_W'(QDEPTH - 1)) ? '0 : p + QPTR_W'(1);
  endfunction

  assign room      = (count_r <= QCNT_W'(QDEPTH - 2));
  assign out_valid = (count_r != '0);
  assign head      = q_r[rd_ptr_r];
  assign rd        = out_valid && out_ready;
  assign n_wr      = {1'b0, push.v0} + {1'b0, push.v1};
  assign first_rec = push.v0 ? push.r0 : push.r1;
  assign wr_ptr_p1 = ptr_inc(wr_ptr_r);

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    if (n_wr == 2'd1) wr_ptr_nxt = wr_ptr_p1;
    else if (n_wr == 2'd2) wr_ptr_nxt = ptr_inc(wr_ptr_p1);
    rd_ptr_nxt = rd ? ptr_inc(rd_ptr_r) : rd_ptr_r;
    count_nxt  = count_r + QCNT_W'(n_wr) - QCNT_W'(rd);
  end

  always_ff @(posedge clk) begin
    if (n_wr != 2'd0) q_r[wr_ptr_r] <= first_rec;
    if (n_wr == 2'd2) q_r[wr_ptr_p1] <= push.r1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= QCNT_W'(QDEPTH))
    else $error("result queue overfilled");

  a_push_room: assert property (@(posedge clk) disable iff (!rst_n)
    (n_wr != 2'd0) |-> (count_r <= QCNT_W'(QDEPTH - 2)))
    else $error("records pushed without room");

  a_empty_ptrs: assert property (@(posedge clk) disable iff (!rst_n)
    (count_r == '0) |-> (wr_ptr_r == rd_ptr_r))
    else $error("queue pointers disagree while empty");

endmodule

// File: verif/stun_message_parser_tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for the STUN message parser: random and directed messages.
module stun_message_parser_tb
  import stunp_pkg::*;
();

  localparam logic [7:0] COLON_CHAR = 8'h3A;
  localparam int unsigned TYPE_END = 2;
  localparam int unsigned LEN_END = 4;
  localparam logic [CFG_IDX_W-1:0] CFG_FIRST_UNMAPPED = CFG_ICE_CONTROLLING + 1'b1;
  localparam logic [CFG_IDX_W-1:0] CFG_LAST_UNMAPPED = '1;
  localparam int unsigned DRAIN_CYCLES = 8;
  localparam int unsigned HOLD_OFF_CYCLES = 80;
  localparam int unsigned MAX_PRINTED = 100;

  typedef enum int unsigned {
    SHAPE_WELL_FORMED,
    SHAPE_TRAILING,
    SHAPE_CUT_PAD,
    SHAPE_OVERRUN,
    SHAPE_TRUNCATED,
    SHAPE_EXTENDED,
    SHAPE_SHORT,
    SHAPE_NOISE
  } shape_t;

  logic                 clk = 1'b0;
  logic                 rst_n;
  logic                 in_valid;
  logic                 in_ready;
  logic [7:0]           in_octet;
  logic                 in_final_octet;
  logic                 out_valid;
  logic                 out_ready;
  logic [1:0]           out_kind;
  logic [7:0]           out_data_byte;
  logic [1:0]           out_username_part;
  logic                 out_attribute_start;
  logic [15:0]          out_message_type;
  logic [1:0]           out_status;
  logic                 out_use_candidate;
  logic                 out_ice_controlled;
  logic                 out_ice_controlling;
  logic                 out_colon_seen;
  logic                 out_end_of_run;
  logic                 cfg_valid;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [15:0]          cfg_data;

  // Parser state mirrored by the predictor
  cfg_codes_t       codes_m;
  logic [POS_W-1:0] pos_m;
  phase_t           phase_m;
  logic [15:0]      msg_type_m;
  logic [15:0]      msg_len_m;
  logic [15:0]      attr_type_m;
  logic [15:0]      attr_len_m;
  logic [15:0]      attr_left_m;
  logic [1:0]       pad_left_m;
  logic [3:0]       flags_m;
  logic             overrun_m;

  result_t     parse_results_due[$];
  int unsigned error_count = 0;
  int unsigned octets_sent = 0;
  bit          sender_idle_en = 1'b0;
  bit          receiver_idle_en = 1'b0;
  int unsigned hold_off_cycles = 0;

  always #5 clk = ~clk;

  stun_message_parser uut (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_valid            (in_valid),
    .in_ready            (in_ready),
    .in_octet            (in_octet),
    .in_final_octet      (in_final_octet),
    .out_valid           (out_valid),
    .out_ready           (out_ready),
    .out_kind            (out_kind),
    .out_data_byte       (out_data_byte),
    .out_username_part   (out_username_part),
    .out_attribute_start (out_attribute_start),
    .out_message_type    (out_message_type),
    .out_status          (out_status),
    .out_use_candidate   (out_use_candidate),
    .out_ice_controlled  (out_ice_controlled),
    .out_ice_controlling (out_ice_controlling),
    .out_colon_seen      (out_colon_seen),
    .out_end_of_run      (out_end_of_run),
    .cfg_valid           (cfg_valid),
    .cfg_ready           (cfg_ready),
    .cfg_index           (cfg_index),
    .cfg_data            (cfg_data)
  );

  function automatic void clear_parse_state();
    pos_m = '0;
    phase_m = PH_HEADER;
    msg_type_m = '0;
    msg_len_m = '0;
    attr_type_m = '0;
    attr_len_m = '0;
    attr_left_m = '0;
    pad_left_m = '0;
    flags_m = '0;
    overrun_m = 1'b0;
  endfunction

  // Advance the parser by one byte and queue the results it produces
  function automatic void parse_octet(logic [7:0] octet, logic fin);
    int unsigned pos;
    int unsigned end_pos;
    int unsigned count;
    result_t     r;
    pos = pos_m;
    end_pos = HDR_BYTES + msg_len_m;
    if (phase_m == PH_HEADER) begin
      if (pos < TYPE_END) begin
        msg_type_m = {msg_type_m[7:0], octet};
      end else if (pos < LEN_END) begin
        msg_len_m = {msg_len_m[7:0], octet};
      end else if (pos >= TXID_FIRST) begin
        r = '0;
        r.kind = KIND_TXID;
        r.data_byte = octet;
        parse_results_due.push_back(r);
      end
      if (pos + 1 >= HDR_BYTES) phase_m = PH_TYPE_HI;
    end else if (phase_m != PH_IGNORE && pos >= end_pos) begin
      phase_m = PH_IGNORE;
    end else begin
      case (phase_m)
        PH_TYPE_HI: begin
          // too few bytes left for an attribute header: ignore the tail
          if (end_pos - pos < ALIGN_BYTES) begin
            phase_m = PH_IGNORE;
          end else begin
            attr_type_m = {octet, 8'h00};
            phase_m = PH_TYPE_LO;
          end
        end
        PH_TYPE_LO: begin
          attr_type_m[7:0] = octet;
          phase_m = PH_LEN_HI;
        end
        PH_LEN_HI: begin
          attr_len_m = {octet, 8'h00};
          phase_m = PH_LEN_LO;
        end
        PH_LEN_LO: begin
          attr_len_m[7:0] = octet;
          if (attr_len_m > end_pos - pos - 1) begin
            overrun_m = 1'b1;
            phase_m = PH_IGNORE;
          end else begin
            if (attr_type_m == codes_m.username) flags_m[FLAG_COLON] = 1'b0;
            else if (attr_type_m == codes_m.use_candidate) flags_m[FLAG_USE] = 1'b1;
            else if (attr_type_m == codes_m.ice_controlled) flags_m[FLAG_CTRLD] = 1'b1;
            else if (attr_type_m == codes_m.ice_controlling) flags_m[FLAG_CTRLG] = 1'b1;
            attr_left_m = attr_len_m;
            phase_m = (attr_len_m == 0) ? PH_TYPE_HI : PH_VALUE;
          end
        end
        PH_VALUE: begin
          if (attr_type_m == codes_m.username) begin
            r = '0;
            r.kind = KIND_USERNAME;
            r.data_byte = octet;
            r.attribute_start = (attr_left_m == attr_len_m);
            if (flags_m[FLAG_COLON]) begin
              r.username_part = PART_REMOTE;
            end else if (octet == COLON_CHAR) begin
              r.username_part = PART_COLON;
              flags_m[FLAG_COLON] = 1'b1;
            end else begin
              r.username_part = PART_LOCAL;
            end
            parse_results_due.push_back(r);
          end
          attr_left_m = attr_left_m - 1'b1;
          if (attr_left_m == 0) begin
            if (attr_len_m[1:0] != 2'd0) begin
              pad_left_m = 2'd0 - attr_len_m[1:0];
              phase_m = PH_PAD;
            end else begin
              phase_m = PH_TYPE_HI;
            end
          end
        end
        PH_PAD: begin
          pad_left_m = pad_left_m - 1'b1;
          if (pad_left_m == 0) phase_m = PH_TYPE_HI;
        end
        default: ;
      endcase
    end

    pos_m = (pos_m == POS_MAX) ? POS_MAX : pos_m + 1'b1;

    if (fin) begin
      count = pos + 1;
      r = '0;
      r.kind = KIND_SUMMARY;
      r.end_of_run = 1'b1;
      if (count < HDR_BYTES) begin
        r.status = ST_SHORT;
      end else if (count != end_pos) begin
        r.status = ST_MISMATCH;
        r.message_type = msg_type_m;
      end else begin
        r.status = overrun_m ? ST_OVERRUN : ST_OK;
        r.message_type = msg_type_m;
        r.use_candidate = flags_m[FLAG_USE];
        r.ice_controlled = flags_m[FLAG_CTRLD];
        r.ice_controlling = flags_m[FLAG_CTRLG];
        r.colon_seen = flags_m[FLAG_COLON];
      end
      parse_results_due.push_back(r);
      clear_parse_state();
    end
  endfunction

  task automatic report_mismatch(string what, int unsigned got, int unsigned want);
    error_count++;
    if (error_count <= MAX_PRINTED)
      $display("%0t: %s: got 0x%0h, expected 0x%0h", $time, what, got, want);
  endtask

  task automatic compare_field(string what, int unsigned got, int unsigned want);
    if (got != want) report_mismatch(what, got, want);
  endtask

  task automatic check_result();
    result_t got;
    result_t want;
    got.kind = out_kind;
    got.data_byte = out_data_byte;
    got.username_part = out_username_part;
    got.attribute_start = out_attribute_start;
    got.message_type = out_message_type;
    got.status = out_status;
    got.use_candidate = out_use_candidate;
    got.ice_controlled = out_ice_controlled;
    got.ice_controlling = out_ice_controlling;
    got.colon_seen = out_colon_seen;
    got.end_of_run = out_end_of_run;
    if (parse_results_due.size() == 0) begin
      report_mismatch("result with nothing outstanding, kind", got.kind, 0);
    end else begin
      want = parse_results_due.pop_front();
      compare_field("kind", got.kind, want.kind);
      compare_field("data_byte", got.data_byte, want.data_byte);
      compare_field("username_part", got.username_part, want.username_part);
      compare_field("attribute_start", got.attribute_start, want.attribute_start);
      compare_field("message_type", got.message_type, want.message_type);
      compare_field("status", got.status, want.status);
      compare_field("use_candidate", got.use_candidate, want.use_candidate);
      compare_field("ice_controlled", got.ice_controlled, want.ice_controlled);
      compare_field("ice_controlling", got.ice_controlling, want.ice_controlling);
      compare_field("colon_seen", got.colon_seen, want.colon_seen);
      compare_field("end_of_run", got.end_of_run, want.end_of_run);
    end
  endtask

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) check_result();
  end

  // Result side: random stalls, plus a long hold-off on request
  initial begin
    out_ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_off_cycles != 0) begin
        out_ready <= 1'b0;
        repeat (hold_off_cycles) @(posedge clk);
        hold_off_cycles = 0;
        out_ready <= 1'b1;
      end else if (receiver_idle_en && $urandom_range(0, 7) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 15)) @(posedge clk);
        out_ready <= 1'b1;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  task automatic send_octet(input logic [7:0] octet, input logic fin, input bit gaps);
    if (gaps && $urandom_range(0, 7) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 15)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_octet <= octet;
    in_final_octet <= fin;
    do @(posedge clk); while (!in_ready);
    parse_octet(octet, fin);
    octets_sent++;
  endtask

  task automatic send_message(ref logic [7:0] msg[$], input bit gaps);
    for (int i = 0; i < msg.size(); i++)
      send_octet(msg[i], i == msg.size() - 1, gaps);
  endtask

  // Drop valid and hold until every outstanding result has drained
  task automatic wait_drained();
    in_valid <= 1'b0;
    while (parse_results_due.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_code(input logic [CFG_IDX_W-1:0] idx, input logic [15:0] value);
    wait_drained();
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    case (idx)
      CFG_USERNAME:        codes_m.username = value;
      CFG_USE_CANDIDATE:   codes_m.use_candidate = value;
      CFG_ICE_CONTROLLED:  codes_m.ice_controlled = value;
      CFG_ICE_CONTROLLING: codes_m.ice_controlling = value;
      default: ;
    endcase
  endtask

  function automatic shape_t pick_shape();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < 45) return SHAPE_WELL_FORMED;
    if (roll < 55) return SHAPE_TRAILING;
    if (roll < 65) return SHAPE_CUT_PAD;
    if (roll < 75) return SHAPE_OVERRUN;
    if (roll < 83) return SHAPE_TRUNCATED;
    if (roll < 90) return SHAPE_EXTENDED;
    if (roll < 95) return SHAPE_SHORT;
    return SHAPE_NOISE;
  endfunction

  function automatic void build_message(ref logic [7:0] msg[$], input shape_t shape);
    logic [7:0]  body[$];
    logic [15:0] atype;
    logic [15:0] alen;
    int unsigned n_attr;
    int unsigned vlen;
    int unsigned k;
    msg.delete();
    if (shape == SHAPE_SHORT || shape == SHAPE_NOISE) begin
      k = (shape == SHAPE_SHORT) ? $urandom_range(1, HDR_BYTES - 1) : $urandom_range(1, 64);
      repeat (k) msg.push_back(8'($urandom));
      return;
    end
    n_attr = $urandom_range(0, 4);
    for (int a = 0; a < n_attr; a++) begin
      case ($urandom_range(0, 5))
        0, 1:    atype = codes_m.username;
        2:       atype = codes_m.use_candidate;
        3:       atype = codes_m.ice_controlled;
        4:       atype = codes_m.ice_controlling;
        default: atype = 16'($urandom);
      endcase
      vlen = (atype == codes_m.username) ? $urandom_range(0, 12) : $urandom_range(0, 8);
      body.push_back(atype[15:8]);
      body.push_back(atype[7:0]);
      body.push_back(8'(vlen >> 8));
      body.push_back(8'(vlen));
      for (int v = 0; v < vlen; v++) begin
        if (atype == codes_m.username && $urandom_range(0, 3) == 0)
          body.push_back(COLON_CHAR);
        else
          body.push_back(8'($urandom));
      end
      // leave the last value unpadded so the declared end cuts the padding
      if (!(shape == SHAPE_CUT_PAD && a == n_attr - 1))
        repeat ((ALIGN_BYTES - vlen % ALIGN_BYTES) % ALIGN_BYTES) body.push_back(8'($urandom));
    end
    if (shape == SHAPE_TRAILING)
      repeat ($urandom_range(1, 3)) body.push_back(8'($urandom));
    if (shape == SHAPE_OVERRUN) begin
      k = $urandom_range(0, 6);
      atype = ($urandom_range(0, 1) == 0) ? codes_m.username : codes_m.use_candidate;
      alen = 16'(k + $urandom_range(1, 300));
      body.push_back(atype[15:8]);
      body.push_back(atype[7:0]);
      body.push_back(alen[15:8]);
      body.push_back(alen[7:0]);
      repeat (k) body.push_back(8'($urandom));
    end
    atype = 16'($urandom);
    alen = 16'(body.size());
    msg.push_back(atype[15:8]);
    msg.push_back(atype[7:0]);
    msg.push_back(alen[15:8]);
    msg.push_back(alen[7:0]);
    repeat (HDR_BYTES - LEN_END) msg.push_back(8'($urandom));
    foreach (body[i]) msg.push_back(body[i]);
    if (shape == SHAPE_TRUNCATED && msg.size() > HDR_BYTES) begin
      k = $urandom_range(HDR_BYTES, msg.size() - 1);
      while (msg.size() > k) void'(msg.pop_back());
    end else if (shape == SHAPE_TRUNCATED || shape == SHAPE_EXTENDED) begin
      repeat ($urandom_range(1, 8)) msg.push_back(8'($urandom));
    end
  endfunction

  task automatic run_random_messages(input int unsigned octet_budget);
    logic [7:0]  msg[$];
    int unsigned stop_at;
    stop_at = octets_sent + octet_budget;
    while (octets_sent < stop_at) begin
      build_message(msg, pick_shape());
      send_message(msg, sender_idle_en && $urandom_range(0, 2) != 0);
    end
  endtask

  // One-byte message, then a minimal valid message with a zero-length use-candidate
  task automatic test_directed();
    logic [7:0] msg[$];
    send_octet(8'hFF, 1'b1, 1'b0);
    msg = '{8'h00, 8'h01, 8'h00, 8'h04, 8'h21, 8'h12, 8'hA4, 8'h42};
    for (int i = 0; i < HDR_BYTES - TXID_FIRST; i++)
      msg.push_back((i % 2) ? 8'hFF : 8'h00);
    msg.push_back(RST_CODE_USE_CANDIDATE[15:8]);
    msg.push_back(RST_CODE_USE_CANDIDATE[7:0]);
    msg.push_back(8'h00);
    msg.push_back(8'h00);
    send_message(msg, 1'b0);
  endtask

  task automatic test_default_codes();
    run_random_messages(300);
  endtask

  // Stall the result side long enough to fill the result queue and back up the input
  task automatic test_output_backpressure();
    logic [7:0] msg[$];
    hold_off_cycles = HOLD_OFF_CYCLES;
    repeat (3) begin
      build_message(msg, SHAPE_WELL_FORMED);
      send_message(msg, 1'b0);
    end
    wait_drained();
    run_random_messages(60);
  endtask

  task automatic test_code_extremes();
    write_code(CFG_USERNAME, 16'h0000);
    write_code(CFG_USE_CANDIDATE, 16'hFFFF);
    write_code(CFG_ICE_CONTROLLED, 16'h0001);
    write_code(CFG_ICE_CONTROLLING, 16'hFFFE);
    run_random_messages(200);
    write_code(CFG_USERNAME, 16'hFFFF);
    write_code(CFG_USE_CANDIDATE, 16'h0000);
    write_code(CFG_ICE_CONTROLLED, 16'($urandom));
    write_code(CFG_ICE_CONTROLLING, 16'($urandom));
    run_random_messages(150);
  endtask

  // Shared codes resolve in priority order; unmapped indexes must change nothing
  task automatic test_colliding_codes();
    logic [15:0] shared_code;
    write_code(CFG_IDX_W'($urandom_range(CFG_FIRST_UNMAPPED, CFG_LAST_UNMAPPED)), 16'hFFFF);
    write_code(CFG_LAST_UNMAPPED, 16'h0000);
    shared_code = 16'($urandom);
    write_code(CFG_USERNAME, shared_code);
    write_code(CFG_USE_CANDIDATE, shared_code);
    write_code(CFG_ICE_CONTROLLED, shared_code);
    write_code(CFG_ICE_CONTROLLING, shared_code);
    run_random_messages(100);
    write_code(CFG_USERNAME, ~shared_code);
    run_random_messages(80);
    write_code(CFG_USE_CANDIDATE, shared_code ^ 16'h00FF);
    run_random_messages(80);
  endtask

  task automatic test_steady_stream();
    sender_idle_en = 1'b0;
    receiver_idle_en = 1'b0;
    write_code(CFG_USERNAME, RST_CODE_USERNAME);
    write_code(CFG_USE_CANDIDATE, RST_CODE_USE_CANDIDATE);
    write_code(CFG_ICE_CONTROLLED, RST_CODE_ICE_CONTROLLED);
    write_code(CFG_ICE_CONTROLLING, RST_CODE_ICE_CONTROLLING);
    run_random_messages(300);
  endtask

  initial begin
    rst_n <= 1'b0;
    in_valid <= 1'b0;
    in_octet <= '0;
    in_final_octet <= 1'b0;
    cfg_valid <= 1'b0;
    cfg_index <= CFG_USERNAME;
    cfg_data <= '0;
    codes_m.username = RST_CODE_USERNAME;
    codes_m.use_candidate = RST_CODE_USE_CANDIDATE;
    codes_m.ice_controlled = RST_CODE_ICE_CONTROLLED;
    codes_m.ice_controlling = RST_CODE_ICE_CONTROLLING;
    clear_parse_state();
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    sender_idle_en = 1'b1;
    receiver_idle_en = 1'b1;

    test_directed();
    test_default_codes();
    test_output_backpressure();
    test_code_extremes();
    test_colliding_codes();
    test_steady_stream();

    in_valid <= 1'b0;
    while (parse_results_due.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (error_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  initial begin
    #20ms;
    $display("*** FAILED ***");
    $finish;
  end

endmodule
